@@ rtl/prnt_pkg.sv @@
// Shared constants, codes and control types for the path resample unit.
package prnt_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned HORIZON     = 20;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned ROOT_W  = SQ_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned USEC_W  = 20;
  localparam int unsigned NUM_W   = ROOT_W + USEC_W;
  localparam int unsigned ITER_W  = $clog2(NUM_W + 1);

  localparam logic [USEC_W-1:0] USEC_PER_S = USEC_W'(1000000);
  localparam logic [CFG_W-1:0]  SPEED_MIN  = CFG_W'(128);
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
  localparam logic [TIME_W-1:0] STAMP_MAX  = '1;
  localparam logic [CFG_W-1:0]  SPACING_RST = CFG_W'(256);
  localparam logic [CFG_W-1:0]  SPEED_RST   = CFG_W'(256);

  // Input mode codes
  localparam logic [1:0] MODE_POINT    = 2'd0;
  localparam logic [1:0] MODE_TICK     = 2'd1;
  localparam logic [1:0] MODE_DECISION = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SPACING = 1'b0;
  localparam logic CFG_SPEED   = 1'b1;

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NOPATH = 1'b1;

  typedef enum logic [1:0] {
    SQ_POINT,   // kept point against input point
    SQ_SCAN,    // stored point against vehicle
    SQ_STEP     // stored point against previous stored point
  } sq_src_e;

  typedef struct packed {
    logic    load_in;
    logic    set_stop;
    sq_src_e sq_src;
    logic    sq_first;
    logic    sq_second;
    logic    sqrt_start;
    logic    acc_sum;
    logic    keep;
    logic    scan_init;
    logic    mem_rd;
    logic    scan_cmp;
    logic    em_init;
    logic    slow_stamp;
    logic    mul_dt;
    logic    div_start;
    logic    add_dt;
    logic    out_load;
    logic    out_empty;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       first;
    logic       last;
    logic       count_zero;
    logic       busy;
    logic       keep_hit;
    logic       scan_last;
    logic       em_first;
    logic       em_last;
    logic       slow;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/prnt_if.sv @@
// Stream and configuration channel interfaces.
interface prnt_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 mode;
  logic signed [prnt_pkg::POS_W-1:0]          pos_x;
  logic signed [prnt_pkg::POS_W-1:0]          pos_y;
  logic                                       first_of_path;
  logic                                       last_of_path;
  logic [prnt_pkg::TIME_W-1:0]                now_time;
  logic [7:0]                                 decision_code;
  modport source (output valid, mode, pos_x, pos_y, first_of_path, last_of_path,
                  now_time, decision_code, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, first_of_path, last_of_path,
                  now_time, decision_code, output ready);
endinterface

interface prnt_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [prnt_pkg::POS_W-1:0] pose_x;
  logic signed [prnt_pkg::POS_W-1:0] pose_y;
  logic [prnt_pkg::TIME_W-1:0]       pose_stamp;
  logic                              last_pose;
  logic                              status;
  modport source (output valid, pose_x, pose_y, pose_stamp, last_pose, status,
                  input ready);
  modport sink   (input valid, pose_x, pose_y, pose_stamp, last_pose, status,
                  output ready);
endinterface

interface prnt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic                         index;
  logic [prnt_pkg::CFG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/prnt_ctrl.sv @@
// Sequencing state machine for point thinning, nearest search and pose emission.
module prnt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  prnt_pkg::sts_t   sts_i,
  output prnt_pkg::cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_PT_SQX, S_PT_SQY, S_PT_ROOT, S_PT_WAIT, S_PT_ACC, S_PT_CHK, S_KEEP,
    S_SCAN_RD, S_SCAN_SQX, S_SCAN_SQY, S_SCAN_CMP,
    S_EM_INIT, S_EM_RD, S_EM_CALC,
    S_ST_SQX, S_ST_SQY, S_ST_ROOT, S_ST_WAIT, S_ST_MUL, S_ST_DIV, S_ST_DWAIT,
    S_ST_ADD, S_EM_OUT, S_EMPTY
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.mode == prnt_pkg::MODE_POINT) begin
          if (sts_i.first) state_d = sts_i.last ? S_IDLE : S_KEEP;
          else             state_d = S_PT_SQX;
        end else if (sts_i.mode == prnt_pkg::MODE_DECISION) begin
          cmd_o.set_stop = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.mode == prnt_pkg::MODE_TICK) begin
          if (sts_i.count_zero) begin
            state_d = S_EMPTY;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d = S_SCAN_RD;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PT_SQX: begin
        cmd_o.sq_src = prnt_pkg::SQ_POINT;
        cmd_o.sq_first = 1'b1;
        state_d = S_PT_SQY;
      end
      S_PT_SQY: begin
        cmd_o.sq_src = prnt_pkg::SQ_POINT;
        cmd_o.sq_second = 1'b1;
        state_d = S_PT_ROOT;
      end
      S_PT_ROOT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_PT_WAIT;
      end
      S_PT_WAIT: if (!sts_i.busy) state_d = S_PT_ACC;
      S_PT_ACC: begin
        cmd_o.acc_sum = 1'b1;
        state_d = S_PT_CHK;
      end
      S_PT_CHK: state_d = sts_i.keep_hit ? S_KEEP : S_IDLE;
      S_KEEP: begin
        cmd_o.keep = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_SCAN_SQX;
      end
      S_SCAN_SQX: begin
        cmd_o.sq_src = prnt_pkg::SQ_SCAN;
        cmd_o.sq_first = 1'b1;
        state_d = S_SCAN_SQY;
      end
      S_SCAN_SQY: begin
        cmd_o.sq_src = prnt_pkg::SQ_SCAN;
        cmd_o.sq_second = 1'b1;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d = sts_i.scan_last ? S_EM_INIT : S_SCAN_RD;
      end
      S_EM_INIT: begin
        cmd_o.em_init = 1'b1;
        state_d = S_EM_RD;
      end
      S_EM_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_EM_CALC;
      end
      S_EM_CALC: begin
        priority if (sts_i.em_first) begin
          state_d = S_EM_OUT;
        end else if (sts_i.slow) begin
          cmd_o.slow_stamp = 1'b1;
          state_d = S_EM_OUT;
        end else begin
          state_d = S_ST_SQX;
        end
      end
      S_ST_SQX: begin
        cmd_o.sq_src = prnt_pkg::SQ_STEP;
        cmd_o.sq_first = 1'b1;
        state_d = S_ST_SQY;
      end
      S_ST_SQY: begin
        cmd_o.sq_src = prnt_pkg::SQ_STEP;
        cmd_o.sq_second = 1'b1;
        state_d = S_ST_ROOT;
      end
      S_ST_ROOT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_ST_WAIT;
      end
      S_ST_WAIT: if (!sts_i.busy) state_d = S_ST_MUL;
      S_ST_MUL: begin
        cmd_o.mul_dt = 1'b1;
        state_d = S_ST_DIV;
      end
      S_ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_ST_DWAIT;
      end
      S_ST_DWAIT: if (!sts_i.busy) state_d = S_ST_ADD;
      S_ST_ADD: begin
        cmd_o.add_dt = 1'b1;
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = sts_i.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.out_empty = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/prnt_dp.sv @@
// Datapath: point store, squared distance, square root and divide units, output register.
module prnt_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  prnt_in_if.sink         in_if,
  prnt_out_if.source      out_if,
  prnt_cfg_if.sink        cfg_if,
  input  prnt_pkg::cmd_t  cmd_i,
  output prnt_pkg::sts_t  sts_o
);

  localparam int unsigned AW  = prnt_pkg::ADDR_W;
  localparam int unsigned CW  = prnt_pkg::CNT_W;
  localparam int unsigned PW  = prnt_pkg::POS_W;
  localparam int unsigned TW  = prnt_pkg::TIME_W;
  localparam int unsigned FW  = prnt_pkg::CFG_W;
  localparam int unsigned DW  = prnt_pkg::DIFF_W;
  localparam int unsigned QW  = prnt_pkg::SQ_W;
  localparam int unsigned RW  = prnt_pkg::ROOT_W;
  localparam int unsigned MW  = prnt_pkg::REM_W;
  localparam int unsigned NW  = prnt_pkg::NUM_W;
  localparam int unsigned IW  = prnt_pkg::ITER_W;
  localparam int unsigned SW  = prnt_pkg::SUM_W;

  // Configuration and decision state
  logic [FW-1:0] spacing_q, speed_q;
  logic          stop_q;

  // Latched input transaction
  logic [1:0]          mode_q;
  logic signed [PW-1:0] in_x_q, in_y_q;
  logic                first_q, last_q;
  logic [TW-1:0]       now_q;
  logic [7:0]          dec_q;

  // Store and thinning state
  logic [2*PW-1:0] mem_q [prnt_pkg::STORE_DEPTH];
  logic [2*PW-1:0] rd_q;
  logic [CW-1:0]   count_q;
  logic [PW-1:0]   kept_x_q, kept_y_q;
  logic [SW-1:0]   sum_q;

  // Search and emission state
  logic [CW-1:0] idx_q, best_q, end_q;
  logic [QW-1:0] sq_q, best_sq_q;
  logic [PW-1:0] prev_x_q, prev_y_q;
  logic [TW-1:0] stamp_q;
  logic          em_first_q;

  // Iterative units
  logic [QW-1:0] rad_q;
  logic [MW-1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [NW-1:0] num_q;
  logic [FW-1:0] drem_q;
  logic [IW-1:0] iter_q;
  logic          is_div_q;

  // Output register
  logic                 out_valid_q;
  logic signed [PW-1:0] out_x_q, out_y_q;
  logic [TW-1:0]        out_stamp_q;
  logic                 out_last_q, out_status_q;

  assign cfg_if.ready = 1'b1;
  // The controller answers the input handshake at the top level
  assign in_if.ready  = 1'b0;

  // Operand select for squared distance
  logic [PW-1:0] ax, ay, bx, by;
  always_comb begin
    unique case (cmd_i.sq_src)
      prnt_pkg::SQ_POINT: begin
        ax = kept_x_q; ay = kept_y_q; bx = in_x_q; by = in_y_q;
      end
      prnt_pkg::SQ_SCAN: begin
        ax = rd_q[2*PW-1:PW]; ay = rd_q[PW-1:0]; bx = in_x_q; by = in_y_q;
      end
      prnt_pkg::SQ_STEP: begin
        ax = rd_q[2*PW-1:PW]; ay = rd_q[PW-1:0]; bx = prev_x_q; by = prev_y_q;
      end
      default: begin
        ax = kept_x_q; ay = kept_y_q; bx = in_x_q; by = in_y_q;
      end
    endcase
  end

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        mx, my, mop;
  logic [QW-1:0]        sq_prod;
  assign dx  = $signed({ax[PW-1], ax}) - $signed({bx[PW-1], bx});
  assign dy  = $signed({ay[PW-1], ay}) - $signed({by[PW-1], by});
  assign mx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign my  = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign mop = cmd_i.sq_second ? my : mx;
  assign sq_prod = mop * mop;

  // One square-root digit or one quotient bit per cycle
  logic [MW+1:0] srem2, strial;
  logic          sge;
  logic [FW:0]   drem2;
  logic          dge;
  logic [FW-1:0] speed_eff;
  assign srem2  = {rem_q, rad_q[QW-1:QW-2]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = srem2 >= strial;
  assign speed_eff = stop_q ? '0 : speed_q;
  assign drem2  = {drem_q, num_q[NW-1]};
  assign dge    = drem2 >= {1'b0, speed_eff};

  // Saturating additions
  logic [SW:0]   sum_ext;
  logic [TW:0]   stamp_ext;
  logic          stamp_ovf;
  assign sum_ext   = {1'b0, sum_q} + (SW+1)'(root_q);
  assign stamp_ext = (TW+1)'(stamp_q) + (TW+1)'(num_q);
  assign stamp_ovf = (num_q[NW-1:TW] != '0) || stamp_ext[TW];

  logic          full;
  logic [CW-1:0] span;
  assign full = (count_q == CW'(prnt_pkg::STORE_DEPTH));
  assign span = count_q - best_q;

  logic out_take;
  assign out_take = out_valid_q && out_if.ready;

  // Status toward the controller
  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.first      = first_q;
    sts_o.last       = last_q;
    sts_o.count_zero = (count_q == '0);
    sts_o.busy       = (iter_q != '0);
    sts_o.keep_hit   = (sum_q > SW'(spacing_q));
    sts_o.scan_last  = (idx_q + CW'(1) == count_q);
    sts_o.em_first   = em_first_q;
    sts_o.em_last    = (idx_q + CW'(1) == end_q);
    sts_o.slow       = (speed_eff < prnt_pkg::SPEED_MIN);
    sts_o.out_free   = !out_valid_q || out_if.ready;
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.keep && !full) begin
      mem_q[count_q[AW-1:0]] <= {in_x_q, in_y_q};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q  <= in_if.mode;
      in_x_q  <= in_if.pos_x;
      in_y_q  <= in_if.pos_y;
      first_q <= in_if.first_of_path;
      last_q  <= in_if.last_of_path;
      now_q   <= in_if.now_time;
      dec_q   <= in_if.decision_code;
    end
    if (cmd_i.sq_first)  sq_q <= sq_prod;
    if (cmd_i.sq_second) sq_q <= sq_q + sq_prod;
    if (cmd_i.scan_cmp && (idx_q == '0 || sq_q < best_sq_q)) begin
      best_q    <= idx_q;
      best_sq_q <= sq_q;
    end
    if (cmd_i.em_init) begin
      end_q   <= (span > CW'(prnt_pkg::HORIZON)) ? best_q + CW'(prnt_pkg::HORIZON)
                                                 : count_q;
      stamp_q <= now_q;
    end
    if (cmd_i.slow_stamp) stamp_q <= now_q;
    if (cmd_i.add_dt) stamp_q <= stamp_ovf ? prnt_pkg::STAMP_MAX : stamp_ext[TW-1:0];
    if (cmd_i.out_load) begin
      prev_x_q <= rd_q[2*PW-1:PW];
      prev_y_q <= rd_q[PW-1:0];
    end
    // Square root: start or step
    if (cmd_i.sqrt_start) begin
      rad_q  <= sq_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (iter_q != '0 && !is_div_q) begin
      rad_q  <= {rad_q[QW-3:0], 2'b00};
      rem_q  <= sge ? MW'(srem2 - strial) : MW'(srem2);
      root_q <= {root_q[RW-2:0], sge};
    end
    // Divide: scale, start or step; quotient shifts into num_q
    if (cmd_i.mul_dt) begin
      num_q <= NW'(root_q) * NW'(prnt_pkg::USEC_PER_S);
    end else if (iter_q != '0 && is_div_q) begin
      num_q  <= {num_q[NW-2:0], dge};
    end
    if (cmd_i.div_start) begin
      drem_q <= '0;
    end else if (iter_q != '0 && is_div_q) begin
      drem_q <= dge ? FW'(drem2 - {1'b0, speed_eff}) : drem2[FW-1:0];
    end
    if (cmd_i.out_load) begin
      out_x_q      <= rd_q[2*PW-1:PW];
      out_y_q      <= rd_q[PW-1:0];
      out_stamp_q  <= stamp_q;
      out_last_q   <= sts_o.em_last;
      out_status_q <= prnt_pkg::STATUS_OK;
    end else if (cmd_i.out_empty) begin
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_stamp_q  <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= prnt_pkg::STATUS_NOPATH;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= prnt_pkg::SPACING_RST;
      speed_q     <= prnt_pkg::SPEED_RST;
      stop_q      <= 1'b0;
      count_q     <= '0;
      kept_x_q    <= '0;
      kept_y_q    <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      em_first_q  <= 1'b0;
      iter_q      <= '0;
      is_div_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          prnt_pkg::CFG_SPACING: spacing_q <= cfg_if.data;
          prnt_pkg::CFG_SPEED:   speed_q   <= cfg_if.data;
          default: ;
        endcase
      end
      if (cmd_i.set_stop) stop_q <= (dec_q == '0);
      if (cmd_i.acc_sum) begin
        sum_q <= (sum_ext > (SW+1)'(prnt_pkg::SUM_MAX)) ? prnt_pkg::SUM_MAX
                                                        : sum_ext[SW-1:0];
      end
      if (cmd_i.keep) begin
        if (!full) count_q <= count_q + CW'(1);
        kept_x_q <= in_x_q;
        kept_y_q <= in_y_q;
        sum_q    <= '0;
      end
      // Advance scan and emission index
      priority if (cmd_i.scan_init) idx_q <= '0;
      else if (cmd_i.em_init)       idx_q <= best_q;
      else if (cmd_i.scan_cmp || cmd_i.out_load) idx_q <= idx_q + CW'(1);
      if (cmd_i.em_init)       em_first_q <= 1'b1;
      else if (cmd_i.out_load) em_first_q <= 1'b0;
      // Iteration counter shared by the root and divide units
      priority if (cmd_i.sqrt_start) begin
        iter_q   <= IW'(RW);
        is_div_q <= 1'b0;
      end else if (cmd_i.div_start) begin
        iter_q   <= IW'(NW);
        is_div_q <= 1'b1;
      end else if (iter_q != '0) begin
        iter_q <= iter_q - IW'(1);
      end
      // Hold result until taken
      if (cmd_i.out_load || cmd_i.out_empty) out_valid_q <= 1'b1;
      else if (out_take)                     out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.pose_x     = out_x_q;
  assign out_if.pose_y     = out_y_q;
  assign out_if.pose_stamp = out_stamp_q;
  assign out_if.last_pose  = out_last_q;
  assign out_if.status     = out_status_q;

endmodule

@@ rtl/path_resample_nearest_timestamp_unit.sv @@
// Top level of the path resample unit: controller and datapath.
//
// Channel  | dir | payload
// in_i     | in  | mode, pos_x, pos_y, first_of_path, last_of_path, now_time, decision_code
// out_o    | out | pose_x, pose_y, pose_stamp, last_pose, status
// cfg_i    | in  | index (0 point_spacing, 1 travel speed), data
//
// One transaction at a time; in_i is ready only while the controller is idle.
// Path point: one not first of its path goes through the 33-step square root unit.
// Tick: each stored point is read, squared and compared in the nearest scan; then up to
// HORIZON poses; each but the first takes 33 root and 53 divide steps if speed >= SPEED_MIN.
// Reset clears counters and flags at once; the store needs no clearing pass.
// The output register lets the next pose be computed while one waits on out_o.
module path_resample_nearest_timestamp_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  prnt_in_if.sink     in_i,
  prnt_out_if.source  out_o,
  prnt_cfg_if.sink    cfg_i
);

  prnt_pkg::cmd_t cmd;
  prnt_pkg::sts_t sts;
  prnt_in_if      in_dp ();

  // Forward input payload to datapath; readiness comes from the controller
  assign in_dp.valid         = in_i.valid;
  assign in_dp.mode          = in_i.mode;
  assign in_dp.pos_x         = in_i.pos_x;
  assign in_dp.pos_y         = in_i.pos_y;
  assign in_dp.first_of_path = in_i.first_of_path;
  assign in_dp.last_of_path  = in_i.last_of_path;
  assign in_dp.now_time      = in_i.now_time;
  assign in_dp.decision_code = in_i.decision_code;

  prnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prnt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_dp),
    .out_if (out_o),
    .cfg_if (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

@@ rtl/prnt_checker.sv @@
// Port-level checks for the path resample unit and their binding.
module prnt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pose_x,
  input logic [47:0] pose_stamp,
  input logic        last_pose,
  input logic        status
);

  // A stalled result holds its pose_x and pose_stamp
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(pose_stamp))
    else $error("result changed while stalled");

  // A no-path result is marked last, with zero pose_x and pose_stamp
  a_nopath: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status |-> last_pose && pose_x == '0 && pose_stamp == '0)
    else $error("malformed no-path result");

  // One transaction in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

bind path_resample_nearest_timestamp_unit prnt_checker u_prnt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .pose_x     (out_o.pose_x),
  .pose_stamp (out_o.pose_stamp),
  .last_pose  (out_o.last_pose),
  .status     (out_o.status)
);

@@ bench/path_resample_nearest_timestamp_unit_checker.sv @@
// Channel monitor that predicts trajectory poses and compares them with the block output.
module path_resample_nearest_timestamp_unit_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  prnt_in_if         in_mon,
  prnt_out_if        out_mon,
  prnt_cfg_if        cfg_mon,
  output int         fail_count_o,
  output int         pending_o
);
  import prnt_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TIME_W-1:0]       stamp;
    logic                    last;
    logic                    status;
  } pose_t;

  // Predicted state of the path store
  logic signed [POS_W-1:0] path_x [STORE_DEPTH];
  logic signed [POS_W-1:0] path_y [STORE_DEPTH];
  int unsigned             path_len;
  logic signed [POS_W-1:0] anchor_x, anchor_y;
  logic [SUM_W-1:0]        travel_sum;
  logic                    stopped;
  logic [CFG_W-1:0]        spacing, speed_cfg;

  pose_t poses_due [$];
  int    fails;
  int    due_count;

  assign fail_count_o = fails;
  assign pending_o    = due_count;

  // Squared Euclidean distance, 66 bits wide
  function automatic logic [65:0] sq_span(input logic signed [31:0] ax, ay, bx, by);
    longint    dx, dy;
    logic [65:0] ux, uy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    ux = 66'(dx);
    uy = 66'(dy);
    return ux * ux + uy * uy;
  endfunction

  // Floor of the Euclidean distance
  function automatic logic [63:0] span(input logic signed [31:0] ax, ay, bx, by);
    logic [65:0] sq, root, cand;
    sq   = sq_span(ax, ay, bx, by);
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (66'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    return root[63:0];
  endfunction

  function automatic void keep_point(input logic signed [31:0] x, y);
    if (path_len < STORE_DEPTH) begin
      path_x[path_len] = x;
      path_y[path_len] = y;
      path_len++;
    end
    anchor_x   = x;
    anchor_y   = y;
    travel_sum = '0;
  endfunction

  // Work out the poses caused by one input transaction
  function automatic void predict_poses();
    logic [63:0]       d, dt, total;
    logic [65:0]       best_sq, sq;
    int unsigned       best, stop_at;
    logic [TIME_W-1:0] stamp;
    logic [CFG_W-1:0]  speed;
    pose_t             p;
    case (in_mon.mode)
      MODE_POINT: begin
        if (in_mon.first_of_path) begin
          if (!in_mon.last_of_path) keep_point(in_mon.pos_x, in_mon.pos_y);
        end else begin
          d = span(anchor_x, anchor_y, in_mon.pos_x, in_mon.pos_y);
          total = 64'(travel_sum) + d;
          travel_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
          if (travel_sum > SUM_W'(spacing)) keep_point(in_mon.pos_x, in_mon.pos_y);
        end
      end
      MODE_DECISION: stopped = (in_mon.decision_code == 8'd0);
      MODE_TICK: begin
        if (path_len == 0) begin
          p = '{x: '0, y: '0, stamp: '0, last: 1'b1, status: STATUS_NOPATH};
          poses_due.insert(poses_due.size(), p);
        end else begin
          best    = 0;
          best_sq = sq_span(path_x[0], path_y[0], in_mon.pos_x, in_mon.pos_y);
          for (int unsigned i = 1; i < path_len; i++) begin
            sq = sq_span(path_x[i], path_y[i], in_mon.pos_x, in_mon.pos_y);
            if (sq < best_sq) begin
              best_sq = sq;
              best    = i;
            end
          end
          stop_at = (path_len - best > HORIZON) ? best + HORIZON : path_len;
          speed   = stopped ? '0 : speed_cfg;
          stamp   = in_mon.now_time;
          for (int unsigned i = best; i < stop_at; i++) begin
            if (i != best) begin
              if (speed < SPEED_MIN) begin
                stamp = in_mon.now_time;
              end else begin
                d  = span(path_x[i], path_y[i], path_x[i-1], path_y[i-1]);
                dt = d * 64'd1000000 / 64'(speed);
                total = 64'(stamp) + dt;
                stamp = (dt > 64'(STAMP_MAX) - 64'(stamp)) ? STAMP_MAX : total[TIME_W-1:0];
              end
            end
            p = '{x: path_x[i], y: path_y[i], stamp: stamp, last: (i + 1 == stop_at),
                  status: STATUS_OK};
            poses_due.insert(poses_due.size(), p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compare each pose, then advance the prediction on new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      path_len   = 0;
      anchor_x   = '0;
      anchor_y   = '0;
      travel_sum = '0;
      stopped    = 1'b0;
      spacing    = SPACING_RST;
      speed_cfg  = SPEED_RST;
      fails      = 0;
      poses_due.delete();
      due_count  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (poses_due.size() == 0) begin
          $display("%0t: pose with none expected: x=%0d y=%0d stamp=%0d", $time,
                   out_mon.pose_x, out_mon.pose_y, out_mon.pose_stamp);
          fails++;
        end else begin
          e = poses_due.pop_front();
          if (out_mon.pose_x !== e.x) begin
            $display("%0t: pose_x expected %0d actual %0d", $time, e.x, out_mon.pose_x);
            fails++;
          end
          if (out_mon.pose_y !== e.y) begin
            $display("%0t: pose_y expected %0d actual %0d", $time, e.y, out_mon.pose_y);
            fails++;
          end
          if (out_mon.pose_stamp !== e.stamp) begin
            $display("%0t: pose_stamp expected %0d actual %0d", $time, e.stamp,
                     out_mon.pose_stamp);
            fails++;
          end
          if (out_mon.last_pose !== e.last) begin
            $display("%0t: last_pose expected %0b actual %0b", $time, e.last,
                     out_mon.last_pose);
            fails++;
          end
          if (out_mon.status !== e.status) begin
            $display("%0t: status expected %0b actual %0b", $time, e.status, out_mon.status);
            fails++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_SPACING) spacing = cfg_mon.data;
        else speed_cfg = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) predict_poses();
      due_count = poses_due.size();
    end
  end

endmodule

@@ bench/path_resample_nearest_timestamp_unit_test.sv @@
// Top of the path resample regression: clock, reset, stimulus and verdict.
module path_resample_nearest_timestamp_unit_test;
  import prnt_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet = 1'b0;
  int   cycles = 0;
  int   fail_count, pending;
  int   stall_left = 0;
  logic signed [31:0] walk_x = 0, walk_y = 0;

  prnt_in_if  in_ch ();
  prnt_out_if out_ch ();
  prnt_cfg_if cfg_ch ();

  path_resample_nearest_timestamp_unit dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .out_o (out_ch), .cfg_i (cfg_ch)
  );

  path_resample_nearest_timestamp_unit_checker checker_u (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_mon (in_ch), .out_mon (out_ch),
    .cfg_mon (cfg_ch), .fail_count_o (fail_count), .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("path_resample_nearest_timestamp_unit regression: fail");
      $finish;
    end
  end

  // Stall the pose channel in random bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = (stall_left == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left   = $urandom_range(1, 16);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] md, input logic signed [31:0] x, y,
                           input logic first, last, input logic [47:0] now_us,
                           input logic [7:0] code);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
    in_ch.valid         = 1'b1;
    in_ch.mode          = md;
    in_ch.pos_x         = x;
    in_ch.pos_y         = y;
    in_ch.first_of_path = first;
    in_ch.last_of_path  = last;
    in_ch.now_time      = now_us;
    in_ch.decision_code = code;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // Hold until every pose has come and the block has settled
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [47:0] rand_now();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // Step the path walk by a small random offset
  task automatic walk_step(input int reach);
    walk_x += $signed($urandom_range(0, 2 * reach)) - reach;
    walk_y += $signed($urandom_range(0, 2 * reach)) - reach;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, walk_x + $signed($urandom_range(0, 4000)) - 2000,
              walk_y + $signed($urandom_range(0, 4000)) - 2000, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), rand_now(), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      walk_step(600);
      send_item(MODE_POINT, walk_x, walk_y, i == 0, i == len - 1, rand_now(),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int pick;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_POINT;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.first_of_path = 1'b0;
    in_ch.last_of_path = 1'b0;
    in_ch.now_time = '0;
    in_ch.decision_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SPACING;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty store, unknown mode, decisions, extreme points
    send_item(MODE_TICK, 32'sh7fffffff, 32'sh80000000, 1, 1, '1, 8'hff);
    send_item(2'd3, '1, '1, 1, 1, '1, 8'hff);
    send_item(MODE_DECISION, 0, 0, 0, 0, 0, 8'd0);
    send_item(MODE_DECISION, '1, '1, 1, 1, '1, 8'hff);
    write_reg(CFG_SPACING, 16'd0);
    write_reg(CFG_SPEED, 16'hffff);
    send_item(MODE_POINT, 5, 5, 0, 0, 0, 0);
    send_item(MODE_POINT, 32'sh80000000, 32'sh80000000, 1, 0, 0, 0);
    send_item(MODE_POINT, 32'sh7fffffff, 32'sh7fffffff, 0, 1, 0, 0);
    send_item(MODE_POINT, 99, 99, 1, 1, 0, 0);
    send_item(MODE_TICK, 32'sh80000000, 32'sh80000000, 0, 0, 48'hffff_ffff_fff0, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 48'h0, 0);
    send_item(MODE_DECISION, 0, 0, 0, 0, 0, 8'd0);
    send_item(MODE_TICK, 32'sh80000000, 32'sh80000000, 0, 0, rand_now(), 0);
    send_item(MODE_DECISION, 0, 0, 0, 0, 0, 8'd1);
    write_reg(CFG_SPEED, 16'd127);
    send_item(MODE_TICK, 32'sh80000000, 32'sh80000000, 0, 0, rand_now(), 0);
    write_reg(CFG_SPEED, 16'd128);
    send_item(MODE_TICK, 32'sh80000000, 32'sh80000000, 0, 0, 48'hffff_ff00_0000, 0);
    write_reg(CFG_SPACING, 16'hffff);
    send_item(MODE_POINT, 70000, 0, 0, 0, 0, 0);
    send_item(MODE_POINT, 0, 0, 0, 0, 0, 0);
    write_reg(CFG_SPACING, 16'd256);
    write_reg(CFG_SPEED, 16'd256);

    // Random: mostly well-formed messages and ticks, some noise
    for (int n = 0; n < 125; n++) begin
      if (n == 105) quiet = 1'b1;
      if (n % 30 == 29) begin
        write_reg(CFG_SPACING, ($urandom_range(0, 3) == 0) ? 16'hffff
                                                           : 16'($urandom_range(0, 2000)));
        case ($urandom_range(0, 3))
          0: write_reg(CFG_SPEED, 16'd0);
          1: write_reg(CFG_SPEED, 16'hffff);
          2: write_reg(CFG_SPEED, 16'd127);
          default: write_reg(CFG_SPEED, 16'($urandom_range(128, 65535)));
        endcase
      end
      if (n == 60) drain();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_message($urandom_range(2, 8));
      end else if (pick < 78) begin
        send_tick();
      end else if (pick < 86) begin
        send_item(MODE_DECISION, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand_now(),
                  ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
      end else if (pick < 91) begin
        send_item(MODE_POINT, $urandom(), $urandom(), 1, 1, rand_now(),
                  8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        walk_step(900);
        send_item(MODE_POINT, walk_x, walk_y, 0, 1'($urandom_range(0, 1)), rand_now(), 0);
      end else begin
        send_item(2'd3, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand_now(), 8'($urandom_range(0, 255)));
      end
    end

    // Lay down a long message, then tick at both ends and in between
    write_reg(CFG_SPACING, 16'd0);
    write_reg(CFG_SPEED, 16'd300);
    send_message(60);
    send_tick();
    send_item(MODE_TICK, 32'sh80000000, 32'sh80000000, 0, 0, rand_now(), 0);
    send_item(MODE_TICK, 32'sh7fffffff, 32'sh7fffffff, 0, 0, rand_now(), 0);
    send_item(MODE_TICK, $urandom(), $urandom(), 0, 0, rand_now(), 0);

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("path_resample_nearest_timestamp_unit regression: pass");
    else
      $display("path_resample_nearest_timestamp_unit regression: fail");
    $finish;
  end

endmodule
